// ----- hdl/test_vector_pin_checker_macros.svh -----
// Assertion macros shared by the vector engine RTL.
// The using module must have clk and rst in scope.
`ifndef TEST_VECTOR_PIN_CHECKER_MACROS_SVH
`define TEST_VECTOR_PIN_CHECKER_MACROS_SVH

// Same-cycle implication.
`define TVPC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vector engine check failed");

// Next-cycle implication.
`define TVPC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vector engine check failed");

`endif

// ----- hdl/tvpc_pkg.sv -----
// ----------------------------------------------------------------------------
// tvpc_pkg
// Types, codes and default sizes for the test vector pin checker.
// ----------------------------------------------------------------------------
package tvpc_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int PORT_COUNT  = 3;

  localparam int PIN_W   = 24;
  localparam int OP_W    = 2;
  localparam int LIDX_W  = 10;
  localparam int STAT_W  = 3;
  localparam int COUNT_W = 11;
  localparam int EXP_W   = 4;
  localparam int REP_W   = 15;
  localparam int CIDX_W  = 3;

  localparam logic [EXP_W-1:0] MAX_EXP = 4'd14;

  // Item operations
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_START  = 2'd1;
  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_LOADED = 3'd0;
  localparam logic [STAT_W-1:0] ST_CONT   = 3'd1;
  localparam logic [STAT_W-1:0] ST_PASS   = 3'd2;
  localparam logic [STAT_W-1:0] ST_FAIL   = 3'd3;
  localparam logic [STAT_W-1:0] ST_REJECT = 3'd4;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_USED_MASK  = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_INPUT_MASK = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_PULLUP     = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_SEQ_MODE   = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_COUNT      = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_EXPONENT   = 3'd5;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [LIDX_W-1:0] load_index;
    logic [PIN_W-1:0]  vector_word;
    logic [PIN_W-1:0]  pin_sample;
  } in_item_t;

  typedef struct packed {
    logic [PIN_W-1:0]  drive_value;
    logic [STAT_W-1:0] status;
  } out_item_t;

  typedef struct packed {
    logic [PIN_W-1:0]   used_mask;
    logic [PIN_W-1:0]   input_mask;
    logic [PIN_W-1:0]   pullup_mask;
    logic               sequential_mode;
    logic [COUNT_W-1:0] vector_count;
    logic [EXP_W-1:0]   repeat_exponent;
  } cfg_t;

  typedef struct packed {
    logic running;
    logic mismatch_seen;
  } flags_t;

  typedef struct packed {
    logic wr_en;
    logic fwd_en;
  } req_t;

  typedef enum logic [0:0] {
    FSM_IDLE,
    FSM_EXEC
  } fsm_t;

endpackage

// ----- hdl/test_vector_pin_checker.sv -----
// ----------------------------------------------------------------------------
// test_vector_pin_checker
// Tester vector engine: vector table, run sequencing and pin compare.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid / item_stall / item): one beat per command.
//     op load writes vector_word at load_index, op start begins a run,
//     op sample hands in the pins read back for the current vector.
//   result channel (result_valid / result_stall / result): exactly one beat
//     per item, carrying the next drive value and a status code.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): register
//     writes, always ready; write only while no item is in flight.
// An accepted item moves to the execute state; its result beat is loaded into
//   the output register once that register is free, and no new item is taken
//   until then. The result waits for the registered read of the vector table.
// Reset clears run state and registers and drops any pending result. The
//   vector table has no clearing pass: entries are undefined until loaded.
// A stalled result holds in the output register; the engine takes one more
//   item, then holds item_stall until the result register frees up.
// ----------------------------------------------------------------------------
`include "test_vector_pin_checker_macros.svh"

module test_vector_pin_checker #(
  parameter int TABLE_DEPTH = tvpc_pkg::TABLE_DEPTH,
  parameter int PORT_COUNT  = tvpc_pkg::PORT_COUNT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  tvpc_pkg::in_item_t            item,
  output logic                          result_valid,
  input  logic                          result_stall,
  output tvpc_pkg::out_item_t           result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tvpc_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [tvpc_pkg::PIN_W-1:0]    cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int PW = tvpc_pkg::PIN_W;
  localparam logic [tvpc_pkg::REP_W-1:0] REP_CAP =
    tvpc_pkg::REP_W'(1) << tvpc_pkg::MAX_EXP;

  tvpc_pkg::fsm_t               state;
  tvpc_pkg::fsm_t               state_next;
  tvpc_pkg::cfg_t               cfg;
  tvpc_pkg::in_item_t           ex_item;
  tvpc_pkg::flags_t             flags;
  tvpc_pkg::flags_t             flags_next;
  tvpc_pkg::req_t               req;
  tvpc_pkg::out_item_t          result_next;
  logic [AW-1:0]                position;
  logic [AW-1:0]                position_next;
  logic [tvpc_pkg::REP_W-1:0]   repeats;
  logic [tvpc_pkg::REP_W-1:0]   repeats_next;
  logic [PW-1:0]                cur_vec;
  logic [PW-1:0]                cur_vec_next;
  logic [AW-1:0]                wr_addr;
  logic [PW-1:0]                wr_data;
  logic [AW-1:0]                rd_addr;
  logic [PW-1:0]                rd_data;
  logic                         accept;
  logic                         exec_fire;

  // Configuration registers; writes never stall.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tvpc_pkg::CFG_USED_MASK:  cfg.used_mask       <= cfg_data;
        tvpc_pkg::CFG_INPUT_MASK: cfg.input_mask      <= cfg_data;
        tvpc_pkg::CFG_PULLUP:     cfg.pullup_mask     <= cfg_data;
        tvpc_pkg::CFG_SEQ_MODE:   cfg.sequential_mode <= cfg_data[0];
        tvpc_pkg::CFG_COUNT:      cfg.vector_count    <= cfg_data[tvpc_pkg::COUNT_W-1:0];
        tvpc_pkg::CFG_EXPONENT:   cfg.repeat_exponent <= cfg_data[tvpc_pkg::EXP_W-1:0];
        default: begin
          // indexes past the register list are dropped
        end
      endcase
    end
  end

  // Sequencer: take an item, then execute once the table word is back and
  // the result register can take the beat.
  always_comb begin
    state_next = state;
    case (state)
      tvpc_pkg::FSM_IDLE: begin
        if (item_valid) begin
          state_next = tvpc_pkg::FSM_EXEC;
        end
      end
      tvpc_pkg::FSM_EXEC: begin
        if (exec_fire) begin
          state_next = tvpc_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_next = tvpc_pkg::FSM_IDLE;
      end
    endcase
  end

  always_comb begin
    item_stall = 1'b1;
    exec_fire  = 1'b0;
    case (state)
      tvpc_pkg::FSM_IDLE: begin
        item_stall = 1'b0;
      end
      tvpc_pkg::FSM_EXEC: begin
        exec_fire = !result_valid || !result_stall;
      end
      default: begin
        item_stall = 1'b1;
      end
    endcase
  end

  assign accept = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tvpc_pkg::FSM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Vector table: loads write at accept, the word for the next drive value
  // is read at accept and consumed in the execute cycle.
  tvpc_ram #(
    .WIDTH (PW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (accept && req.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tvpc_step #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .PORT_COUNT  (PORT_COUNT)
  ) u_step (
    .cfg           (cfg),
    .item          (item),
    .position      (position),
    .repeats       (repeats),
    .flags         (flags),
    .cur_vec       (cur_vec),
    .ex_item       (ex_item),
    .rd_data       (rd_data),
    .req           (req),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .rd_addr       (rd_addr),
    .position_next (position_next),
    .repeats_next  (repeats_next),
    .flags_next    (flags_next),
    .cur_vec_next  (cur_vec_next),
    .result        (result_next)
  );

  // Run state; advance only when a result beat is formed.
  always_ff @(posedge clk) begin
    if (rst) begin
      flags    <= '0;
      position <= '0;
      repeats  <= '0;
    end else if (exec_fire) begin
      flags    <= flags_next;
      position <= position_next;
      repeats  <= repeats_next;
    end
  end

  // Hold the accepted item and the vector under test. A load that lands on
  // the current position during a run replaces the compare word directly.
  always_ff @(posedge clk) begin
    if (accept) begin
      ex_item <= item;
    end
    if (accept && req.fwd_en) begin
      cur_vec <= wr_data;
    end else if (exec_fire) begin
      cur_vec <= cur_vec_next;
    end
  end

  // Output register: load on execute, drop once the receiver takes the beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (exec_fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      result <= result_next;
    end
  end

  `TVPC_ASSERT_NXT(a_accept_exec, accept, state == tvpc_pkg::FSM_EXEC)
  `TVPC_ASSERT_IMP(a_result_src, $rose(result_valid), $past(state) == tvpc_pkg::FSM_EXEC)
  `TVPC_ASSERT_IMP(a_rep_bound, 1'b1, repeats <= REP_CAP)
  `TVPC_ASSERT_NXT(a_fwd_word, accept && req.fwd_en, cur_vec == $past(wr_data))
  `TVPC_ASSERT_NXT(a_done_idle,
    exec_fire && (result_next.status == tvpc_pkg::ST_PASS ||
                  result_next.status == tvpc_pkg::ST_FAIL),
    !flags.running)

endmodule

// ----- hdl/tvpc_ram.sv -----
// ----------------------------------------------------------------------------
// tvpc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tvpc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/tvpc_step.sv -----
// ----------------------------------------------------------------------------
// tvpc_step
// Per-item decision logic: table access for an accepted item, then the
// compare, run bookkeeping and result once the table word is back.
// ----------------------------------------------------------------------------
module tvpc_step #(
  parameter int TABLE_DEPTH = tvpc_pkg::TABLE_DEPTH,
  parameter int PORT_COUNT  = tvpc_pkg::PORT_COUNT
) (
  input  tvpc_pkg::cfg_t                        cfg,
  input  tvpc_pkg::in_item_t                    item,
  input  logic [$clog2(TABLE_DEPTH)-1:0]        position,
  input  logic [tvpc_pkg::REP_W-1:0]            repeats,
  input  tvpc_pkg::flags_t                      flags,
  input  logic [tvpc_pkg::PIN_W-1:0]            cur_vec,
  input  tvpc_pkg::in_item_t                    ex_item,
  input  logic [tvpc_pkg::PIN_W-1:0]            rd_data,
  output tvpc_pkg::req_t                        req,
  output logic [$clog2(TABLE_DEPTH)-1:0]        wr_addr,
  output logic [tvpc_pkg::PIN_W-1:0]            wr_data,
  output logic [$clog2(TABLE_DEPTH)-1:0]        rd_addr,
  output logic [$clog2(TABLE_DEPTH)-1:0]        position_next,
  output logic [tvpc_pkg::REP_W-1:0]            repeats_next,
  output tvpc_pkg::flags_t                      flags_next,
  output logic [tvpc_pkg::PIN_W-1:0]            cur_vec_next,
  output tvpc_pkg::out_item_t                   result
);

  localparam int AW   = $clog2(TABLE_DEPTH);
  localparam int CW_T = $clog2(TABLE_DEPTH + 1);
  localparam int CW   = (CW_T > tvpc_pkg::COUNT_W) ? CW_T : tvpc_pkg::COUNT_W;
  localparam int PW   = tvpc_pkg::PIN_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic [PW-1:0] PIN_MASK =
    (8 * PORT_COUNT >= PW) ? {PW{1'b1}} : PW'((64'd1 << (8 * PORT_COUNT)) - 64'd1);

  logic [CW-1:0]                 cnt_ext;
  logic [CW-1:0]                 eff_count;
  logic [CW-1:0]                 pos_inc;
  logic [CW-1:0]                 li_ext;
  logic                          adv;
  logic [PW-1:0]                 drive;
  logic [PW-1:0]                 care;
  logic                          check;
  logic                          miss;
  logic [tvpc_pkg::EXP_W-1:0]    exp_eff;
  logic [tvpc_pkg::REP_W-1:0]    rep_inc;
  logic [tvpc_pkg::REP_W-1:0]    rep_lim;

  // Shared run arithmetic; state does not move between accept and execute.
  always_comb begin
    cnt_ext   = CW'(cfg.vector_count);
    eff_count = (cnt_ext > DEPTH_C) ? DEPTH_C : cnt_ext;
    pos_inc   = CW'(position) + CW'(1);
    adv       = pos_inc < eff_count;
    li_ext    = CW'(item.load_index);
  end

  // Table access for the item being accepted.
  always_comb begin
    req.wr_en  = (item.op == tvpc_pkg::OP_LOAD) && (li_ext < DEPTH_C);
    req.fwd_en = req.wr_en && flags.running && (li_ext == CW'(position));
    wr_addr    = AW'(item.load_index);
    wr_data    = item.vector_word & PIN_MASK;
    rd_addr    = ((item.op == tvpc_pkg::OP_SAMPLE) && adv) ? AW'(pos_inc) : '0;
  end

  // Compare and bookkeeping once the table word is back.
  always_comb begin
    drive   = cfg.used_mask & ((rd_data & cfg.input_mask) |
              (cfg.pullup_mask & ~cfg.input_mask)) & PIN_MASK;
    care    = ~cfg.input_mask & cfg.used_mask & PIN_MASK;
    check   = !cfg.sequential_mode || position[0];
    miss    = flags.mismatch_seen ||
              (check && (((ex_item.pin_sample ^ cur_vec) & care) != '0));
    exp_eff = (cfg.repeat_exponent > tvpc_pkg::MAX_EXP) ?
              tvpc_pkg::MAX_EXP : cfg.repeat_exponent;
    rep_inc = repeats + tvpc_pkg::REP_W'(1);
    rep_lim = tvpc_pkg::REP_W'(1) << exp_eff;

    position_next      = position;
    repeats_next       = repeats;
    flags_next         = flags;
    cur_vec_next       = cur_vec;
    result.drive_value = '0;
    result.status      = tvpc_pkg::ST_REJECT;

    case (ex_item.op)
      tvpc_pkg::OP_LOAD: begin
        result.status = tvpc_pkg::ST_LOADED;
      end
      tvpc_pkg::OP_START: begin
        position_next            = '0;
        repeats_next             = '0;
        flags_next.mismatch_seen = 1'b0;
        if (eff_count == '0) begin
          flags_next.running = 1'b0;
          result.status      = tvpc_pkg::ST_PASS;
        end else begin
          flags_next.running = 1'b1;
          result.drive_value = drive;
          result.status      = tvpc_pkg::ST_CONT;
          cur_vec_next       = rd_data;
        end
      end
      tvpc_pkg::OP_SAMPLE: begin
        if (flags.running) begin
          flags_next.mismatch_seen = miss;
          if (adv) begin
            position_next      = AW'(pos_inc);
            result.drive_value = drive;
            result.status      = tvpc_pkg::ST_CONT;
            cur_vec_next       = rd_data;
          end else if (miss) begin
            flags_next.running = 1'b0;
            position_next      = '0;
            result.status      = tvpc_pkg::ST_FAIL;
          end else begin
            repeats_next  = rep_inc;
            position_next = '0;
            if (rep_inc >= rep_lim) begin
              flags_next.running = 1'b0;
              result.status      = tvpc_pkg::ST_PASS;
            end else begin
              result.drive_value = drive;
              result.status      = tvpc_pkg::ST_CONT;
              cur_vec_next       = rd_data;
            end
          end
        end
      end
      default: begin
        result.status = tvpc_pkg::ST_REJECT;
      end
    endcase
  end

endmodule

// ----- sim/test_vector_pin_checker_tb.sv -----
// ----------------------------------------------------------------------------
// test_vector_pin_checker_tb
// Self-checking bench for the tester vector engine. A scoreboard predicts
// every result beat from the accepted command beats. Stimulus is a directed
// opener, randomized phases of vector loads and runs, then directed corner runs.
// ----------------------------------------------------------------------------
module test_vector_pin_checker_tb;

  localparam int PIN_W       = tvpc_pkg::PIN_W;
  localparam int OP_W        = tvpc_pkg::OP_W;
  localparam int LIDX_W      = tvpc_pkg::LIDX_W;
  localparam int CIDX_W      = tvpc_pkg::CIDX_W;
  localparam int REP_W       = tvpc_pkg::REP_W;
  localparam int COUNT_W     = tvpc_pkg::COUNT_W;
  localparam int EXP_W       = tvpc_pkg::EXP_W;
  localparam int TABLE_DEPTH = tvpc_pkg::TABLE_DEPTH;

  // Op code that the engine must reject like an idle sample.
  localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

  logic clk;
  logic rst = 1'b1;

  logic                 item_valid = 1'b0;
  logic                 item_stall;
  tvpc_pkg::in_item_t   item = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  tvpc_pkg::out_item_t  result;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [PIN_W-1:0]  cfg_data  = '0;

  test_vector_pin_checker dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Command beats waiting for the driver, and the results they should cause.
  tvpc_pkg::in_item_t  command_queue[$];
  tvpc_pkg::out_item_t predicted_answers[$];

  int  queued_count = 0;
  int  answers_seen = 0;
  int  useful_items = 0;
  int  fail_count   = 0;
  // Set to switch off all random idling on both channels.
  bit  quiet        = 1'b0;

  // Register copy, updated when the write beats have gone through.
  tvpc_pkg::cfg_t regs = '0;

  // Scoreboard copy of the engine state.
  logic [PIN_W-1:0] vec_mem [0:TABLE_DEPTH-1];
  logic [LIDX_W-1:0] cur_pos = '0;
  logic [REP_W-1:0]  reps_done = '0;
  bit                miss_latched = 1'b0;
  bit                run_active = 1'b0;

  // Stimulus-side view of the table, kept in queue order.
  logic [PIN_W-1:0] planned_vec [0:TABLE_DEPTH-1];
  bit               planned_ok  [0:TABLE_DEPTH-1];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Engine prediction
  // --------------------------------------------------------------------------

  // Vectors per repetition; the count saturates at the table depth.
  function automatic int live_span();
    int c;
    c = regs.vector_count;
    return (c > TABLE_DEPTH) ? TABLE_DEPTH : c;
  endfunction

  // Repetitions per run; the exponent saturates at fourteen.
  function automatic int live_repeats();
    return 1 << ((regs.repeat_exponent > tvpc_pkg::MAX_EXP) ?
                 tvpc_pkg::MAX_EXP : regs.repeat_exponent);
  endfunction

  // Pin levels to drive for one vector: inputs from the vector, the rest pulled.
  function automatic logic [PIN_W-1:0] drive_levels(input logic [PIN_W-1:0] v);
    return regs.used_mask & ((v & regs.input_mask) | (regs.pullup_mask & ~regs.input_mask));
  endfunction

  // Advance the scoreboard state by one command beat and queue its result.
  task automatic predict_answer(input tvpc_pkg::in_item_t it);
    tvpc_pkg::out_item_t ans;
    logic [PIN_W-1:0]    care;
    int                  span;
    ans.drive_value = '0;
    ans.status      = tvpc_pkg::ST_REJECT;
    span = live_span();
    case (it.op)
      tvpc_pkg::OP_LOAD: begin
        vec_mem[it.load_index] = it.vector_word;
        ans.status = tvpc_pkg::ST_LOADED;
      end
      tvpc_pkg::OP_START: begin
        cur_pos      = '0;
        reps_done    = '0;
        miss_latched = 1'b0;
        run_active   = (span != 0);
        if (span == 0) begin
          ans.status = tvpc_pkg::ST_PASS;
        end else begin
          ans.status      = tvpc_pkg::ST_CONT;
          ans.drive_value = drive_levels(vec_mem[0]);
        end
      end
      tvpc_pkg::OP_SAMPLE: begin
        if (run_active) begin
          // Compare only used output pins; sequential mode skips even slots.
          care = ~regs.input_mask & regs.used_mask;
          if (!regs.sequential_mode || cur_pos[0]) begin
            if ((it.pin_sample & care) != (vec_mem[cur_pos] & care))
              miss_latched = 1'b1;
          end
          if (int'(cur_pos) + 1 < span) begin
            cur_pos         = cur_pos + 1'b1;
            ans.status      = tvpc_pkg::ST_CONT;
            ans.drive_value = drive_levels(vec_mem[cur_pos]);
          end else if (miss_latched) begin
            run_active = 1'b0;
            cur_pos    = '0;
            ans.status = tvpc_pkg::ST_FAIL;
          end else begin
            reps_done = reps_done + 1'b1;
            cur_pos   = '0;
            if (int'(reps_done) >= live_repeats()) begin
              run_active = 1'b0;
              ans.status = tvpc_pkg::ST_PASS;
            end else begin
              ans.status      = tvpc_pkg::ST_CONT;
              ans.drive_value = drive_levels(vec_mem[0]);
            end
          end
        end
      end
      default: begin
      end
    endcase
    predicted_answers.push_back(ans);
  endtask

  // Compare one result beat against the oldest prediction.
  task automatic check_answer(input tvpc_pkg::out_item_t got);
    tvpc_pkg::out_item_t want;
    answers_seen++;
    if (predicted_answers.size() == 0) begin
      fail_count++;
      $error("result beat with no command pending: drive_value %06h status %0d",
             got.drive_value, got.status);
    end else begin
      want = predicted_answers.pop_front();
      if (got.drive_value !== want.drive_value) begin
        fail_count++;
        $error("drive_value: expected %06h, got %06h", want.drive_value, got.drive_value);
      end
      if (got.status !== want.status) begin
        fail_count++;
        $error("status: expected %0d, got %0d", want.status, got.status);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Command driver: present queued beats, predict each one as it is taken.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall)
        predict_answer(item);
      // Hold a stalled beat; otherwise advance or drop valid to idle.
      if (!item_valid || !item_stall) begin
        if (command_queue.size() != 0 && !(!quiet && $urandom_range(99) < 8)) begin
          item       <= command_queue.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: check each accepted beat, stall at random.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall)
        check_answer(result);
      result_stall <= !quiet && ($urandom_range(99) < 8);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic tvpc_pkg::in_item_t make_item(input logic [OP_W-1:0] op,
                                                   input logic [LIDX_W-1:0] idx,
                                                   input logic [PIN_W-1:0] word,
                                                   input logic [PIN_W-1:0] pins);
    tvpc_pkg::in_item_t it;
    it.op          = op;
    it.load_index  = idx;
    it.vector_word = word;
    it.pin_sample  = pins;
    return it;
  endfunction

  task automatic push_cmd(input tvpc_pkg::in_item_t it);
    command_queue.push_back(it);
    queued_count++;
    if (it.op != OP_UNKNOWN)
      useful_items++;
  endtask

  task automatic queue_load(input logic [LIDX_W-1:0] idx, input logic [PIN_W-1:0] word);
    planned_vec[idx] = word;
    planned_ok[idx]  = 1'b1;
    push_cmd(make_item(tvpc_pkg::OP_LOAD, idx, word, PIN_W'($urandom)));
  endtask

  // Load every slot below n that has not been written yet.
  task automatic fill_table(input int n);
    int i;
    for (i = 0; i < n; i++)
      if (!planned_ok[i])
        queue_load(LIDX_W'(i), PIN_W'($urandom));
  endtask

  // Queue the readback for slot p. Don't-care pins get random levels; with
  // flip set, care pins are inverted (at least one, if any). Raise hit when the engine checks it.
  task automatic queue_sample(input int p, input bit flip, inout bit hit);
    logic [PIN_W-1:0] care;
    logic [PIN_W-1:0] bump;
    logic [PIN_W-1:0] pins;
    care = ~regs.input_mask & regs.used_mask;
    pins = (planned_vec[p] & care) | (PIN_W'($urandom) & ~care);
    if (flip) begin
      bump = PIN_W'($urandom) & care;
      if (bump == '0)
        bump = care & (~care + 1'b1);
      pins = pins ^ bump;
      if (bump != '0 && (!regs.sequential_mode || (p % 2 == 1)))
        hit = 1'b1;
    end
    push_cmd(make_item(tvpc_pkg::OP_SAMPLE, LIDX_W'($urandom), PIN_W'($urandom), pins));
  endtask

  // Stray beat: a load, an unknown op, or (only where idle_ok) a raw sample.
  task automatic queue_stray(input bit idle_ok);
    case ($urandom_range(idle_ok ? 2 : 1))
      0: queue_load(LIDX_W'($urandom_range(TABLE_DEPTH - 1)), PIN_W'($urandom));
      1: push_cmd(make_item(OP_UNKNOWN, LIDX_W'($urandom), PIN_W'($urandom),
                            PIN_W'($urandom)));
      default: push_cmd(make_item(tvpc_pkg::OP_SAMPLE, LIDX_W'($urandom),
                                  PIN_W'($urandom), PIN_W'($urandom)));
    endcase
  endtask

  // Queue a whole run: start, then samples for every slot of every repetition.
  // Stop after a repetition that carries a checked mismatch, since the engine
  // reports the failure there and goes idle. Abandon at random to exercise a
  // restart while running.
  task automatic queue_run(input int fail_odds, input int noise_odds, input int quit_odds);
    int span;
    int rounds;
    int r;
    int p;
    bit hit;
    span   = live_span();
    rounds = live_repeats();
    hit    = 1'b0;
    push_cmd(make_item(tvpc_pkg::OP_START, LIDX_W'($urandom), PIN_W'($urandom),
                       PIN_W'($urandom)));
    for (r = 0; r < rounds && !hit; r++) begin
      for (p = 0; p < span; p++) begin
        if ($urandom_range(99) < quit_odds)
          return;
        if ($urandom_range(99) < noise_odds)
          queue_stray(1'b0);
        queue_sample(p, $urandom_range(99) < fail_odds, hit);
      end
    end
    if ($urandom_range(9) == 0)
      queue_stray(1'b1);
  endtask

  // Block until every queued beat has its result, then let the pipe settle.
  task automatic wait_idle();
    do @(posedge clk); while (answers_seen != queued_count);
    repeat (2) @(posedge clk);
  endtask

  // One write beat; valid stays high for a following write.
  task automatic put_reg(input logic [CIDX_W-1:0] idx, input logic [PIN_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic write_settings(input tvpc_pkg::cfg_t c);
    put_reg(tvpc_pkg::CFG_USED_MASK,  c.used_mask);
    put_reg(tvpc_pkg::CFG_INPUT_MASK, c.input_mask);
    put_reg(tvpc_pkg::CFG_PULLUP,     c.pullup_mask);
    put_reg(tvpc_pkg::CFG_SEQ_MODE,   PIN_W'(c.sequential_mode));
    put_reg(tvpc_pkg::CFG_COUNT,      PIN_W'(c.vector_count));
    put_reg(tvpc_pkg::CFG_EXPONENT,   PIN_W'(c.repeat_exponent));
    cfg_valid <= 1'b0;
    regs = c;
  endtask

  function automatic logic [PIN_W-1:0] pick_mask();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return PIN_W'($urandom);
    endcase
  endfunction

  // Random settings; keep runs short so most of the time goes to many runs.
  function automatic tvpc_pkg::cfg_t roll_settings();
    tvpc_pkg::cfg_t c;
    int             r;
    c.used_mask       = pick_mask();
    c.input_mask      = pick_mask();
    c.pullup_mask     = pick_mask();
    c.sequential_mode = 1'($urandom_range(1));
    r = $urandom_range(99);
    if (r < 5)
      c.vector_count = '0;
    else if (r < 85)
      c.vector_count = COUNT_W'($urandom_range(1, 8));
    else
      c.vector_count = COUNT_W'($urandom_range(9, 40));
    r = $urandom_range(99);
    if (c.vector_count > 8)
      c.repeat_exponent = EXP_W'($urandom_range(1));
    else if (r < 55)
      c.repeat_exponent = '0;
    else if (r < 80)
      c.repeat_exponent = EXP_W'(1);
    else if (r < 93)
      c.repeat_exponent = EXP_W'(2);
    else
      c.repeat_exponent = EXP_W'($urandom_range(3, 4));
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    tvpc_pkg::cfg_t c;
    bit             hit;
    int             i;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Idle engine: reject stray samples and unknown ops, pass an empty run,
    // then load the corner slots.
    c = '0;
    c.used_mask   = '1;
    c.input_mask  = 24'h0F0F0F;
    c.pullup_mask = 24'hA5A5A5;
    write_settings(c);
    push_cmd(make_item(tvpc_pkg::OP_SAMPLE, '0, '0, '1));
    push_cmd(make_item(OP_UNKNOWN, '1, '1, '0));
    push_cmd(make_item(tvpc_pkg::OP_START, '0, '0, '0));
    queue_load('0, '1);
    queue_load(LIDX_W'(TABLE_DEPTH - 1), '0);
    queue_load(LIDX_W'(1), '0);

    // Two slots, two repetitions: restart mid-run, load during a run, pass,
    // then a checked mismatch that fails at the end of the repetition.
    wait_idle();
    c.input_mask      = 24'hF0F0F0;
    c.pullup_mask     = 24'h0F0F0F;
    c.vector_count    = COUNT_W'(2);
    c.repeat_exponent = EXP_W'(1);
    write_settings(c);
    hit = 1'b0;
    push_cmd(make_item(tvpc_pkg::OP_START, '0, '0, '0));
    queue_sample(0, 1'b0, hit);
    push_cmd(make_item(tvpc_pkg::OP_START, '0, '0, '0));
    queue_sample(0, 1'b0, hit);
    queue_load(LIDX_W'(5), 24'h5A5A5A);
    queue_sample(1, 1'b0, hit);
    queue_sample(0, 1'b0, hit);
    queue_sample(1, 1'b0, hit);
    push_cmd(make_item(tvpc_pkg::OP_START, '0, '0, '0));
    queue_sample(0, 1'b1, hit);
    queue_sample(1, 1'b0, hit);
    push_cmd(make_item(tvpc_pkg::OP_SAMPLE, '1, '1, '1));

    // Sequential mode: a mismatch in the even slot is ignored.
    wait_idle();
    c.input_mask      = '0;
    c.sequential_mode = 1'b1;
    c.repeat_exponent = '0;
    write_settings(c);
    push_cmd(make_item(tvpc_pkg::OP_START, '0, '0, '0));
    queue_sample(0, 1'b1, hit);
    queue_sample(1, 1'b0, hit);

    // Random phases: fresh settings, table fill, then a few runs each.
    useful_items = 0;
    while (useful_items < 600) begin
      wait_idle();
      write_settings(roll_settings());
      fill_table(live_span());
      repeat ($urandom_range(3)) queue_stray(1'b1);
      repeat ($urandom_range(1, 3)) queue_run(3, 5, 1);
    end

    // Count above the table depth: the run keeps stepping past any short
    // count; leave it running and restart below.
    wait_idle();
    c = roll_settings();
    c.vector_count    = '1;
    c.repeat_exponent = '0;
    write_settings(c);
    fill_table(49);
    push_cmd(make_item(tvpc_pkg::OP_START, '0, '0, '0));
    for (i = 0; i < 48; i++)
      queue_sample(i, 1'b0, hit);

    // Exponent above fourteen on a one-vector run, with no idling at all:
    // every repetition must keep going.
    wait_idle();
    quiet = 1'b1;
    c = roll_settings();
    c.vector_count    = COUNT_W'(1);
    c.repeat_exponent = '1;
    write_settings(c);
    fill_table(1);
    push_cmd(make_item(tvpc_pkg::OP_START, '0, '0, '0));
    for (i = 0; i < 160; i++)
      queue_sample(0, 1'b0, hit);

    wait_idle();
    quiet = 1'b0;
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("test_vector_pin_checker verification clean");
    end else begin
      $display("test_vector_pin_checker verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("test_vector_pin_checker verification failed");
    $finish;
  end

endmodule
